// ===== sv/ssp_pkg.sv =====
// Shared constants and arithmetic helpers for the sprite screen projection unit.
// Depends on nothing; imported by sprite_screen_projection_unit.
package ssp_pkg;

   // Screen geometry
   localparam int SCREEN_W = 800;
   localparam int SCREEN_H = 600;
   localparam int HALF_W   = SCREEN_W / 2;
   localparam int HALF_H   = SCREEN_H / 2;

   // Magnitude width of the column numerator HALF_W * (tx + ty)
   localparam int NUM_W    = 32 + $clog2(HALF_W + 1);
   // Signed width for column and row edge arithmetic
   localparam int EDGE_W   = NUM_W + 2;
   // Dividend of the size division: SCREEN_H in Q16.16
   localparam logic [NUM_W-1:0] SIZE_NUM = NUM_W'(64'(SCREEN_H) * 64'd65536);

   // Quotient bits of the inverse determinant (2^32 / det)
   localparam int INV_STEPS = 33;

   // Register indexes
   localparam logic [2:0] REG_PLAYER_POS_X = 3'd0;
   localparam logic [2:0] REG_PLAYER_POS_Y = 3'd1;
   localparam logic [2:0] REG_VIEW_DIR_X   = 3'd2;
   localparam logic [2:0] REG_VIEW_DIR_Y   = 3'd3;
   localparam logic [2:0] REG_CAM_PLANE_X  = 3'd4;
   localparam logic [2:0] REG_CAM_PLANE_Y  = 3'd5;

   // Saturate to the signed 32-bit range
   function automatic logic signed [31:0] sat32(input logic signed [48:0] v);
      logic signed [31:0] r;
      if (v > 49'sd2147483647)
         r = 32'sh7FFF_FFFF;
      else if (v < -49'sd2147483648)
         r = 32'sh8000_0000;
      else
         r = v[31:0];
      return r;
   endfunction

   // Q16.16 product scaling, rounding toward minus infinity
   function automatic logic signed [47:0] floor16(input logic signed [63:0] p);
      return $signed(p[63:16]);
   endfunction

   // Clamp an edge to 0 .. lim-1
   function automatic logic [9:0] clamp_edge(input logic signed [EDGE_W-1:0] v,
                                             input int lim);
      logic [9:0] r;
      if (v < 0)
         r = 10'd0;
      else if (v > EDGE_W'(lim - 1))
         r = 10'(lim - 1);
      else
         r = v[9:0];
      return r;
   endfunction

endpackage

// ===== sv/sprite_screen_projection_unit.sv =====
// Throughput: one sprite per cycle unless a stalled output holds the pipeline;
// the two restoring dividers (33 and NUM_W stages, one quotient bit per stage)
// and the multiplier stages are fully pipelined.
// Reset: synchronous, active high; clears all valid bits and loads the
// camera registers with their default pose. Data registers are not reset.
module sprite_screen_projection_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_sprite_pos_x,
   input  logic signed [31:0] req_sprite_pos_y,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_in_front,
   output logic signed [15:0] rsp_centre_column,
   output logic [15:0]        rsp_size_pixels,
   output logic [9:0]         rsp_first_row,
   output logic [9:0]         rsp_last_row,
   output logic [9:0]         rsp_first_column,
   output logic [9:0]         rsp_last_column,
   output logic signed [31:0] rsp_depth,
   input  logic               csr_we,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_wdata
);
   import ssp_pkg::*;

   // Configuration registers
   logic signed [31:0] player_pos_x_ff, player_pos_y_ff;
   logic signed [31:0] view_dir_x_ff, view_dir_y_ff;
   logic signed [31:0] cam_plane_x_ff, cam_plane_y_ff;

   // Pipeline control
   logic en;
   logic accept;

   // Stage 1: offsets and determinant products
   logic               s1_v_ff;
   logic signed [31:0] s1_dx_ff, s1_dy_ff;
   logic signed [63:0] s1_pa_ff, s1_pb_ff;

   // Stage 2: determinant and numerator products
   logic               s2_v_ff;
   logic signed [31:0] s2_det_ff;
   logic signed [63:0] s2_pxa_ff, s2_pxb_ff, s2_pya_ff, s2_pyb_ff;
   logic [31:0]        s2_det_mag_in;

   // Inverse determinant divider, entry 0 is loaded from stage 2
   logic               d1_v_ff    [0:INV_STEPS];
   logic [31:0]        d1_rem_ff  [0:INV_STEPS];
   logic [32:0]        d1_q_ff    [0:INV_STEPS];
   logic [31:0]        d1_d_ff    [0:INV_STEPS];
   logic               d1_neg_ff  [0:INV_STEPS];
   logic               d1_dz_ff   [0:INV_STEPS];
   logic signed [31:0] d1_numx_ff [0:INV_STEPS];
   logic signed [31:0] d1_numy_ff [0:INV_STEPS];

   // Stage 4: products with the inverse determinant
   logic signed [31:0] inv_in;
   logic               s4_v_ff, s4_dz_ff;
   logic signed [63:0] s4_px_ff, s4_py_ff;

   // Stage 5: camera-space coordinates
   logic               s5_v_ff, s5_dz_ff;
   logic signed [31:0] s5_tx_ff, s5_ty_ff;

   // Column and size divider, entry 0 is loaded from stage 5
   logic signed [32:0]      sum_in;
   logic signed [NUM_W:0]   num_in;
   logic                    d2_v_ff    [0:NUM_W];
   logic [NUM_W-1:0]        d2_num_ff  [0:NUM_W];
   logic [31:0]             d2_ra_ff   [0:NUM_W];
   logic [31:0]             d2_rb_ff   [0:NUM_W];
   logic [NUM_W-1:0]        d2_qa_ff   [0:NUM_W];
   logic [NUM_W-1:0]        d2_qb_ff   [0:NUM_W];
   logic [31:0]             d2_d_ff    [0:NUM_W];
   logic                    d2_neg_ff  [0:NUM_W];
   logic                    d2_nul_ff  [0:NUM_W];
   logic signed [31:0]      d2_ty_ff   [0:NUM_W];

   // Stage 7: signed centre and size
   logic                    s7_v_ff, s7_nul_ff;
   logic signed [EDGE_W-1:0] s7_centre_ff;
   logic [NUM_W-1:0]        s7_size_ff;
   logic signed [31:0]      s7_ty_ff;

   // Output register
   logic               rsp_valid_ff;
   logic               o_front_ff;
   logic signed [15:0] o_centre_ff;
   logic [15:0]        o_size_ff;
   logic [9:0]         o_frow_ff, o_lrow_ff, o_fcol_ff, o_lcol_ff;
   logic signed [31:0] o_depth_ff;

   logic signed [EDGE_W-1:0] half_in;
   logic signed [15:0]       centre_sat_in;
   logic [15:0]              size_sat_in;

   // Write configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         player_pos_x_ff <= 32'sd0;
         player_pos_y_ff <= 32'sd0;
         view_dir_x_ff   <= 32'sd0;
         view_dir_y_ff   <= 32'sd65536;
         cam_plane_x_ff  <= 32'sd43253;
         cam_plane_y_ff  <= 32'sd0;
      end else if (csr_we) begin
         case (csr_index)
            REG_PLAYER_POS_X: player_pos_x_ff <= csr_wdata;
            REG_PLAYER_POS_Y: player_pos_y_ff <= csr_wdata;
            REG_VIEW_DIR_X:   view_dir_x_ff   <= csr_wdata;
            REG_VIEW_DIR_Y:   view_dir_y_ff   <= csr_wdata;
            REG_CAM_PLANE_X:  cam_plane_x_ff  <= csr_wdata;
            REG_CAM_PLANE_Y:  cam_plane_y_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Advance unless a finished transaction would land on a stalled output
   assign en        = !(rsp_valid_ff && rsp_stall && s7_v_ff);
   assign req_stall = !en;
   assign accept    = req_valid && en;

   // Stage 1
   always_ff @(posedge clock) begin
      if (reset)
         s1_v_ff <= 1'b0;
      else if (en)
         s1_v_ff <= accept;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_dx_ff <= sat32(49'(req_sprite_pos_x) - 49'(player_pos_x_ff));
         s1_dy_ff <= sat32(49'(req_sprite_pos_y) - 49'(player_pos_y_ff));
         s1_pa_ff <= 64'(cam_plane_x_ff) * 64'(view_dir_y_ff);
         s1_pb_ff <= 64'(cam_plane_y_ff) * 64'(view_dir_x_ff);
      end
   end

   // Stage 2
   always_ff @(posedge clock) begin
      if (reset)
         s2_v_ff <= 1'b0;
      else if (en)
         s2_v_ff <= s1_v_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s2_det_ff <= sat32(49'(floor16(s1_pa_ff)) - 49'(floor16(s1_pb_ff)));
         s2_pxa_ff <= 64'(view_dir_y_ff) * 64'(s1_dx_ff);
         s2_pxb_ff <= 64'(view_dir_x_ff) * 64'(s1_dy_ff);
         s2_pya_ff <= 64'(cam_plane_x_ff) * 64'(s1_dy_ff);
         s2_pyb_ff <= 64'(cam_plane_y_ff) * 64'(s1_dx_ff);
      end
   end

   assign s2_det_mag_in = s2_det_ff[31] ? (~s2_det_ff + 32'd1) : s2_det_ff;

   // Load the inverse determinant divider
   always_ff @(posedge clock) begin
      if (reset)
         d1_v_ff[0] <= 1'b0;
      else if (en)
         d1_v_ff[0] <= s2_v_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d1_rem_ff[0]  <= 32'd0;
         d1_q_ff[0]    <= 33'd0;
         d1_d_ff[0]    <= s2_det_mag_in;
         d1_neg_ff[0]  <= s2_det_ff[31];
         d1_dz_ff[0]   <= (s2_det_ff == 32'sd0);
         d1_numx_ff[0] <= sat32(49'(floor16(s2_pxa_ff)) - 49'(floor16(s2_pxb_ff)));
         d1_numy_ff[0] <= sat32(49'(floor16(s2_pya_ff)) - 49'(floor16(s2_pyb_ff)));
      end
   end

   // Restoring division of 2^32 by |det|, one quotient bit per stage
   for (genvar i = 0; i < INV_STEPS; i++) begin : g_inv
      logic [32:0] trial_in;
      logic        ge_in;

      assign trial_in = {d1_rem_ff[i], (i == 0) ? 1'b1 : 1'b0};
      assign ge_in    = trial_in >= {1'b0, d1_d_ff[i]};

      always_ff @(posedge clock) begin
         if (reset)
            d1_v_ff[i+1] <= 1'b0;
         else if (en)
            d1_v_ff[i+1] <= d1_v_ff[i];
      end

      always_ff @(posedge clock) begin
         if (en) begin
            d1_rem_ff[i+1]  <= ge_in ? 32'(trial_in - {1'b0, d1_d_ff[i]}) : trial_in[31:0];
            d1_q_ff[i+1]    <= {d1_q_ff[i][31:0], ge_in};
            d1_d_ff[i+1]    <= d1_d_ff[i];
            d1_neg_ff[i+1]  <= d1_neg_ff[i];
            d1_dz_ff[i+1]   <= d1_dz_ff[i];
            d1_numx_ff[i+1] <= d1_numx_ff[i];
            d1_numy_ff[i+1] <= d1_numy_ff[i];
         end
      end
   end

   // Apply the sign and saturate the inverse determinant
   always_comb begin
      if (d1_neg_ff[INV_STEPS]) begin
         if (d1_q_ff[INV_STEPS] > 33'h0_8000_0000)
            inv_in = 32'sh8000_0000;
         else
            inv_in = 32'(~d1_q_ff[INV_STEPS] + 33'd1);
      end else begin
         if (d1_q_ff[INV_STEPS] > 33'h0_7FFF_FFFF)
            inv_in = 32'sh7FFF_FFFF;
         else
            inv_in = d1_q_ff[INV_STEPS][31:0];
      end
   end

   // Stage 4
   always_ff @(posedge clock) begin
      if (reset)
         s4_v_ff <= 1'b0;
      else if (en)
         s4_v_ff <= d1_v_ff[INV_STEPS];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s4_dz_ff <= d1_dz_ff[INV_STEPS];
         s4_px_ff <= 64'(inv_in) * 64'(d1_numx_ff[INV_STEPS]);
         s4_py_ff <= 64'(inv_in) * 64'(d1_numy_ff[INV_STEPS]);
      end
   end

   // Stage 5
   always_ff @(posedge clock) begin
      if (reset)
         s5_v_ff <= 1'b0;
      else if (en)
         s5_v_ff <= s4_v_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s5_dz_ff <= s4_dz_ff;
         s5_tx_ff <= sat32(49'(floor16(s4_px_ff)));
         s5_ty_ff <= sat32(49'(floor16(s4_py_ff)));
      end
   end

   // Column numerator
   assign sum_in = 33'(s5_tx_ff) + 33'(s5_ty_ff);
   assign num_in = (NUM_W + 1)'(sum_in) * (NUM_W + 1)'(HALF_W);

   // Load the column and size divider
   always_ff @(posedge clock) begin
      if (reset)
         d2_v_ff[0] <= 1'b0;
      else if (en)
         d2_v_ff[0] <= s5_v_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d2_num_ff[0] <= num_in[NUM_W] ? NUM_W'(-num_in) : num_in[NUM_W-1:0];
         d2_ra_ff[0]  <= 32'd0;
         d2_rb_ff[0]  <= 32'd0;
         d2_qa_ff[0]  <= '0;
         d2_qb_ff[0]  <= '0;
         d2_d_ff[0]   <= s5_ty_ff[31] ? (~s5_ty_ff + 32'd1) : s5_ty_ff;
         d2_neg_ff[0] <= num_in[NUM_W] ^ s5_ty_ff[31];
         d2_nul_ff[0] <= s5_dz_ff || (s5_ty_ff == 32'sd0);
         d2_ty_ff[0]  <= s5_ty_ff;
      end
   end

   // Restoring divisions of |num| and SCREEN_H*2^16 by |ty| side by side
   for (genvar i = 0; i < NUM_W; i++) begin : g_div
      logic [32:0] ta_in, tb_in;
      logic        gea_in, geb_in;

      assign ta_in  = {d2_ra_ff[i], d2_num_ff[i][NUM_W-1]};
      assign tb_in  = {d2_rb_ff[i], SIZE_NUM[NUM_W-1-i]};
      assign gea_in = ta_in >= {1'b0, d2_d_ff[i]};
      assign geb_in = tb_in >= {1'b0, d2_d_ff[i]};

      always_ff @(posedge clock) begin
         if (reset)
            d2_v_ff[i+1] <= 1'b0;
         else if (en)
            d2_v_ff[i+1] <= d2_v_ff[i];
      end

      always_ff @(posedge clock) begin
         if (en) begin
            d2_num_ff[i+1] <= {d2_num_ff[i][NUM_W-2:0], 1'b0};
            d2_ra_ff[i+1]  <= gea_in ? 32'(ta_in - {1'b0, d2_d_ff[i]}) : ta_in[31:0];
            d2_rb_ff[i+1]  <= geb_in ? 32'(tb_in - {1'b0, d2_d_ff[i]}) : tb_in[31:0];
            d2_qa_ff[i+1]  <= {d2_qa_ff[i][NUM_W-2:0], gea_in};
            d2_qb_ff[i+1]  <= {d2_qb_ff[i][NUM_W-2:0], geb_in};
            d2_d_ff[i+1]   <= d2_d_ff[i];
            d2_neg_ff[i+1] <= d2_neg_ff[i];
            d2_nul_ff[i+1] <= d2_nul_ff[i];
            d2_ty_ff[i+1]  <= d2_ty_ff[i];
         end
      end
   end

   // Stage 7: sign the centre column
   always_ff @(posedge clock) begin
      if (reset)
         s7_v_ff <= 1'b0;
      else if (en)
         s7_v_ff <= d2_v_ff[NUM_W];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s7_nul_ff    <= d2_nul_ff[NUM_W];
         s7_centre_ff <= d2_neg_ff[NUM_W] ? -EDGE_W'(d2_qa_ff[NUM_W])
                                          : EDGE_W'(d2_qa_ff[NUM_W]);
         s7_size_ff   <= d2_qb_ff[NUM_W];
         s7_ty_ff     <= d2_ty_ff[NUM_W];
      end
   end

   // Saturate and clamp the drawing window
   assign half_in = EDGE_W'(s7_size_ff >> 1);

   always_comb begin
      if (s7_centre_ff > EDGE_W'(32767))
         centre_sat_in = 16'sh7FFF;
      else if (s7_centre_ff < -EDGE_W'(32768))
         centre_sat_in = 16'sh8000;
      else
         centre_sat_in = s7_centre_ff[15:0];
      size_sat_in = (s7_size_ff > NUM_W'(65535)) ? 16'hFFFF : s7_size_ff[15:0];
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset)
         rsp_valid_ff <= 1'b0;
      else if (en && s7_v_ff)
         rsp_valid_ff <= 1'b1;
      else if (!rsp_stall)
         rsp_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (en && s7_v_ff) begin
         if (s7_nul_ff) begin
            o_front_ff  <= 1'b0;
            o_centre_ff <= 16'sd0;
            o_size_ff   <= 16'd0;
            o_frow_ff   <= 10'd0;
            o_lrow_ff   <= 10'd0;
            o_fcol_ff   <= 10'd0;
            o_lcol_ff   <= 10'd0;
            o_depth_ff  <= 32'sd0;
         end else begin
            o_front_ff  <= !s7_ty_ff[31];
            o_centre_ff <= centre_sat_in;
            o_size_ff   <= size_sat_in;
            o_frow_ff   <= clamp_edge(EDGE_W'(HALF_H) - half_in, SCREEN_H);
            o_lrow_ff   <= clamp_edge(EDGE_W'(HALF_H) + half_in, SCREEN_H);
            o_fcol_ff   <= clamp_edge(s7_centre_ff - half_in, SCREEN_W);
            o_lcol_ff   <= clamp_edge(s7_centre_ff + half_in, SCREEN_W);
            o_depth_ff  <= s7_ty_ff;
         end
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_in_front      = o_front_ff;
   assign rsp_centre_column = o_centre_ff;
   assign rsp_size_pixels   = o_size_ff;
   assign rsp_first_row     = o_frow_ff;
   assign rsp_last_row      = o_lrow_ff;
   assign rsp_first_column  = o_fcol_ff;
   assign rsp_last_column   = o_lcol_ff;
   assign rsp_depth         = o_depth_ff;

endmodule
